>>> design/lzm_pkg.sv
`timescale 1ns / 1ps

package lzm_pkg;

    localparam int LAYER_W = 8;
    localparam int HGT_W   = 9;
    localparam int CNT_W   = 9;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [2:0] RES_REFUSE     = 3'd0;
    localparam logic [2:0] RES_ALLOC_OK   = 3'd1;
    localparam logic [2:0] RES_ALLOC_FAIL = 3'd2;
    localparam logic [2:0] RES_NOCHG      = 3'd3;
    localparam logic [2:0] RES_MOVED      = 3'd4;
    localparam logic [2:0] RES_FREED      = 3'd5;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       k_inc;
        logic       alloc_take;
        logic       plan;
        logic       sh_wr;
        logic       fin_wr;
        logic       free_fin;
        logic       res_set;
        logic [2:0] res_code;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       k_last;
        logic       used_rd;
        logic [1:0] op;
        logic       id_ok;
        logic       hid_old;
        logic       nochg;
        logic       loop;
        logic       sh_last;
        logic       out_busy;
    } t_sts;

endpackage

>>> design/lzm_ifs.sv
`timescale 1ns / 1ps

interface lzm_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [7:0]        layer_id;
    logic signed [8:0] new_height;

    modport source (output valid, output opcode, output layer_id, output new_height,
                    input ready);
    modport sink (input valid, input opcode, input layer_id, input new_height,
                  output ready);
endinterface

interface lzm_rsp_if;
    logic              valid;
    logic              ready;
    logic [7:0]        result_layer;
    logic              ok;
    logic signed [8:0] applied_height;
    logic [8:0]        visible_count;
    logic              refresh_needed;

    modport source (output valid, output result_layer, output ok, output applied_height,
                    output visible_count, output refresh_needed, input ready);
    modport sink (input valid, input result_layer, input ok, input applied_height,
                  input visible_count, input refresh_needed, output ready);
endinterface

>>> design/lzm_ctrl.sv
`timescale 1ns / 1ps

module lzm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lzm_pkg::t_sts i_sts,
    output lzm_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DEC      = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_CHK_ID   = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_FINAL    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.op == lzm_pkg::OP_ALLOC) begin
                    n_state = S_SCAN_CHK;
                end else if ((i_sts.op == lzm_pkg::OP_SET || i_sts.op == lzm_pkg::OP_FREE)
                             && i_sts.id_ok) begin
                    n_state = S_CHK_ID;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = lzm_pkg::RES_REFUSE;
                    n_state        = S_DONE;
                end
            end
            S_SCAN_CHK: begin
                if (!i_sts.used_rd) begin
                    o_cmd.alloc_take = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_code   = lzm_pkg::RES_ALLOC_OK;
                    n_state          = S_DONE;
                end else if (i_sts.k_last) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = lzm_pkg::RES_ALLOC_FAIL;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_CHK_ID: begin
                if (!i_sts.used_rd) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = lzm_pkg::RES_REFUSE;
                    n_state        = S_DONE;
                end else if (i_sts.op == lzm_pkg::OP_FREE && i_sts.hid_old) begin
                    o_cmd.free_fin = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = lzm_pkg::RES_FREED;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.plan = 1'b1;
                    if (i_sts.nochg) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = lzm_pkg::RES_NOCHG;
                        n_state        = S_DONE;
                    end else if (i_sts.loop) begin
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = i_sts.sh_last ? S_FINAL : S_SH_RD;
            end
            S_FINAL: begin
                o_cmd.fin_wr   = 1'b1;
                o_cmd.free_fin = (i_sts.op == lzm_pkg::OP_FREE);
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = lzm_pkg::RES_MOVED;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/lzm_dpath.sv
`timescale 1ns / 1ps

module lzm_dpath #(
    parameter int NUM_LAYERS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzm_pkg::t_cmd     i_cmd,
    output lzm_pkg::t_sts     o_sts,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_layer_id,
    input  logic signed [8:0] i_new_height,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_result_layer,
    output logic              o_ok,
    output logic signed [8:0] o_applied_height,
    output logic [8:0]        o_visible_count,
    output logic              o_refresh_needed
);

    localparam int IW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    logic                    r_used_mem [NUM_LAYERS];
    logic signed [8:0]       r_hgt_mem  [NUM_LAYERS];
    logic [7:0]              r_seq_mem  [NUM_LAYERS];

    logic [1:0]              r_op;
    logic [7:0]              r_id;
    logic signed [8:0]       r_hraw;
    logic [IW-1:0]           r_k;
    logic [8:0]              r_cnt;
    logic                    r_used_rd;
    logic signed [8:0]       r_hgt_rd;
    logic [7:0]              r_seq_rd;
    logic signed [9:0]       r_req;
    logic signed [9:0]       r_old;
    logic signed [9:0]       r_j;
    logic signed [9:0]       r_stop;
    logic                    r_down;

    logic [7:0]              r_rs_layer;
    logic                    r_rs_ok;
    logic signed [8:0]       r_rs_app;
    logic                    r_rs_ref;

    logic                    r_out_vld;
    logic [7:0]              r_out_layer;
    logic                    r_out_ok;
    logic signed [8:0]       r_out_app;
    logic [8:0]              r_out_cnt;
    logic                    r_out_ref;

    logic [IW-1:0]           w_id_idx;
    logic [IW-1:0]           w_used_addr;
    logic signed [9:0]       w_old;
    logic signed [9:0]       w_cnt_s;
    logic signed [9:0]       w_limit;
    logic signed [9:0]       w_reqr;
    logic signed [9:0]       w_reqc;
    logic                    w_full;
    logic                    w_down;
    logic signed [9:0]       w_start;
    logic signed [9:0]       w_stop;
    logic signed [9:0]       w_src;

    assign w_id_idx    = IW'(r_id);
    assign w_used_addr = (r_op == lzm_pkg::OP_ALLOC) ? r_k : w_id_idx;
    assign w_old       = 10'(r_hgt_rd);
    assign w_cnt_s     = signed'({1'b0, r_cnt});
    assign w_limit     = (w_old >= 0) ? (w_cnt_s - 10'sd1) : w_cnt_s;
    assign w_reqr      = 10'(r_hraw);

    always_comb begin
        if (r_op == lzm_pkg::OP_FREE) begin
            w_reqc = -10'sd1;
        end else if (w_reqr > w_limit) begin
            w_reqc = w_limit;
        end else if (w_reqr < -10'sd1) begin
            w_reqc = -10'sd1;
        end else begin
            w_reqc = w_reqr;
        end
    end

    assign w_full  = (w_old < 0) && ({23'b0, r_cnt} >= NUM_LAYERS);
    assign w_down  = !((w_old >= 0) && ((w_reqc > w_old) || (w_reqc < 0)));
    assign w_start = (w_old < 0) ? w_cnt_s : w_old;
    assign w_stop  = (w_reqc < 0) ? (w_cnt_s - 10'sd1) : w_reqc;
    assign w_src   = r_down ? (r_j - 10'sd1) : (r_j + 10'sd1);

    assign o_sts.clr_last = (r_k == IW'(NUM_LAYERS - 1));
    assign o_sts.k_last   = (r_k == IW'(NUM_LAYERS - 1));
    assign o_sts.used_rd  = r_used_rd;
    assign o_sts.op       = r_op;
    assign o_sts.id_ok    = ({24'b0, r_id} < NUM_LAYERS);
    assign o_sts.hid_old  = (r_hgt_rd < 0);
    assign o_sts.nochg    = (w_reqc == w_old) || w_full;
    assign o_sts.loop     = w_down ? (w_start > w_reqc) : (w_start < w_stop);
    assign o_sts.sh_last  = r_down ? ((r_j - 10'sd1) == r_req) : ((r_j + 10'sd1) == r_stop);
    assign o_sts.out_busy = r_out_vld && !i_out_ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_used_mem[r_k] <= 1'b0;
        end else if (i_cmd.alloc_take) begin
            r_used_mem[r_k] <= 1'b1;
        end else if (i_cmd.free_fin) begin
            r_used_mem[w_id_idx] <= 1'b0;
        end
        r_used_rd <= r_used_mem[w_used_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_wr) begin
            r_hgt_mem[IW'(r_seq_rd)] <= 9'(r_j);
        end else if (i_cmd.fin_wr) begin
            r_hgt_mem[w_id_idx] <= 9'(r_req);
        end else if (i_cmd.alloc_take) begin
            r_hgt_mem[r_k] <= -9'sd1;
        end else if (i_cmd.free_fin) begin
            r_hgt_mem[w_id_idx] <= -9'sd1;
        end
        r_hgt_rd <= r_hgt_mem[w_id_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sh_wr) begin
            r_seq_mem[IW'(r_j)] <= r_seq_rd;
        end else if (i_cmd.fin_wr && (r_req >= 0)) begin
            r_seq_mem[IW'(r_req)] <= r_id;
        end
        r_seq_rd <= r_seq_mem[IW'(w_src)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_k <= '0;
            end else if (i_cmd.clr_wr || i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.fin_wr) begin
                if (r_old < 0) begin
                    r_cnt <= r_cnt + 9'd1;
                end else if (r_req < 0) begin
                    r_cnt <= r_cnt - 9'd1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_id   <= i_layer_id;
            r_hraw <= i_new_height;
        end
        if (i_cmd.plan) begin
            r_req  <= w_reqc;
            r_old  <= w_old;
            r_j    <= w_start;
            r_stop <= w_stop;
            r_down <= w_down;
        end else if (i_cmd.sh_wr) begin
            r_j <= w_src;
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_code)
                lzm_pkg::RES_ALLOC_OK: begin
                    r_rs_layer <= 8'(r_k);
                    r_rs_ok    <= 1'b1;
                    r_rs_app   <= -9'sd1;
                    r_rs_ref   <= 1'b0;
                end
                lzm_pkg::RES_ALLOC_FAIL: begin
                    r_rs_layer <= 8'd0;
                    r_rs_ok    <= 1'b0;
                    r_rs_app   <= -9'sd1;
                    r_rs_ref   <= 1'b0;
                end
                lzm_pkg::RES_NOCHG: begin
                    r_rs_layer <= r_id;
                    r_rs_ok    <= 1'b1;
                    r_rs_app   <= r_hgt_rd;
                    r_rs_ref   <= 1'b0;
                end
                lzm_pkg::RES_MOVED: begin
                    r_rs_layer <= r_id;
                    r_rs_ok    <= 1'b1;
                    r_rs_app   <= 9'(r_req);
                    r_rs_ref   <= 1'b1;
                end
                lzm_pkg::RES_FREED: begin
                    r_rs_layer <= r_id;
                    r_rs_ok    <= 1'b1;
                    r_rs_app   <= -9'sd1;
                    r_rs_ref   <= 1'b0;
                end
                default: begin
                    r_rs_layer <= r_id;
                    r_rs_ok    <= 1'b0;
                    r_rs_app   <= -9'sd1;
                    r_rs_ref   <= 1'b0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_layer <= r_rs_layer;
            r_out_ok    <= r_rs_ok;
            r_out_app   <= r_rs_app;
            r_out_cnt   <= r_cnt;
            r_out_ref   <= r_rs_ref;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_result_layer   = r_out_layer;
    assign o_ok             = r_out_ok;
    assign o_applied_height = r_out_app;
    assign o_visible_count  = r_out_cnt;
    assign o_refresh_needed = r_out_ref;

endmodule

>>> design/layer_zorder_manager_top.sv
`timescale 1ns / 1ps
// Layer z-order manager: pool of NUM_LAYERS layers and the bottom-to-top
// order of the visible ones.
// Channels: i_req carries one item (opcode, layer_id, new_height) per
// operation; o_rsp returns exactly one result item per request item.
// Work done from request accept to result valid:
//   allocate  : a scan up to the lowest free layer
//   set height: a shift of each slot passed in the visible order;
//               no shift when the height does not change
//   free      : same as set height to -1, no shift for a hidden layer
//   refusals  : unknown opcode at decode, layer not in use after a read
// One item is worked at a time; the shift loop moves one slot per pass
// (one registered read and one write of the order memory), and that loop
// sets the throughput.
// Reset: a clearing pass over all layers marks every layer free; no
// request is accepted during it.
// A finished result sits in the output register; the next request is
// accepted while it waits, and that request's result holds until the
// receiver takes the earlier one.
module layer_zorder_manager_top #(
    parameter int NUM_LAYERS = 256
) (
    input logic       i_clk,
    input logic       i_rst_n,
    lzm_req_if.sink   i_req,
    lzm_rsp_if.source o_rsp
);

    lzm_pkg::t_cmd w_cmd;
    lzm_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_req.ready = w_in_ready;

    lzm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lzm_dpath #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_req.opcode),
        .i_layer_id       (i_req.layer_id),
        .i_new_height     (i_req.new_height),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_result_layer   (o_rsp.result_layer),
        .o_ok             (o_rsp.ok),
        .o_applied_height (o_rsp.applied_height),
        .o_visible_count  (o_rsp.visible_count),
        .o_refresh_needed (o_rsp.refresh_needed)
    );

endmodule

>>> dv/layer_zorder_manager_top_test.sv
`timescale 1ns / 1ps

module layer_zorder_manager_top_test;

    localparam int NL = 256;
    localparam logic [1:0] OP_BAD = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        layer_id;
        logic signed [8:0] new_height;
    } t_req;

    typedef struct packed {
        logic [7:0]        result_layer;
        logic              ok;
        logic signed [8:0] applied_height;
        logic [8:0]        visible_count;
        logic              refresh_needed;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    lzm_req_if req_if ();
    lzm_rsp_if rsp_if ();

    layer_zorder_manager_top #(.NUM_LAYERS(NL)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // stack model
    bit      used_m[NL];
    int      hgt_m[NL];
    int      seq_m[NL];
    int      top_m;

    t_req    pending_q[$];
    t_rsp    expected_q[$];
    int      errors;
    bit      stim_done;
    bit      hold_send;
    int      send_gap;
    int      recv_gap;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit move_layer(int id, int req);
        int old;
        int lim;
        old = hgt_m[id];
        lim = (old >= 0) ? top_m : top_m + 1;
        if (req > lim) req = lim;
        if (req < -1) req = -1;
        if (req == old) return 0;
        if (req < old) begin
            if (req >= 0) begin
                for (int i = old; i > req; i--) begin
                    seq_m[i] = seq_m[i-1];
                    hgt_m[seq_m[i]] = i;
                end
                seq_m[req] = id;
                hgt_m[id] = req;
            end else begin
                for (int i = old; i < top_m; i++) begin
                    seq_m[i] = seq_m[i+1];
                    hgt_m[seq_m[i]] = i;
                end
                hgt_m[id] = -1;
                top_m--;
            end
        end else if (old >= 0) begin
            for (int i = old; i < req; i++) begin
                seq_m[i] = seq_m[i+1];
                hgt_m[seq_m[i]] = i;
            end
            seq_m[req] = id;
            hgt_m[id] = req;
        end else begin
            if (top_m + 1 >= NL) return 0;
            for (int i = top_m; i >= req; i--) begin
                seq_m[i+1] = seq_m[i];
                hgt_m[seq_m[i+1]] = i + 1;
            end
            seq_m[req] = id;
            hgt_m[id] = req;
            top_m++;
        end
        return 1;
    endfunction

    function automatic t_rsp predict_stack(t_req rq);
        t_rsp r;
        int   id;
        id = int'(rq.layer_id);
        r.result_layer = rq.layer_id;
        r.ok = 0;
        r.applied_height = -9'sd1;
        r.refresh_needed = 0;
        if (rq.opcode == lzm_pkg::OP_ALLOC) begin
            r.result_layer = 0;
            for (int i = 0; i < NL; i++) begin
                if (!used_m[i]) begin
                    used_m[i] = 1;
                    hgt_m[i] = -1;
                    r.result_layer = 8'(i);
                    r.ok = 1;
                    break;
                end
            end
        end else if ((rq.opcode == lzm_pkg::OP_SET || rq.opcode == lzm_pkg::OP_FREE)
                     && id < NL && used_m[id]) begin
            r.ok = 1;
            if (rq.opcode == lzm_pkg::OP_SET) begin
                r.refresh_needed = move_layer(id, int'(rq.new_height));
                r.applied_height = 9'(hgt_m[id]);
            end else begin
                if (hgt_m[id] >= 0) r.refresh_needed = move_layer(id, -1);
                used_m[id] = 0;
                hgt_m[id] = -1;
            end
        end
        r.visible_count = 9'(top_m + 1);
        return r;
    endfunction

    function automatic void push_req(logic [1:0] op, int id, int h);
        t_req rq;
        rq.opcode = op;
        rq.layer_id = 8'(id);
        rq.new_height = 9'(h);
        pending_q.push_back(rq);
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 0;
            send_gap <= 0;
        end else if (req_if.valid && !req_if.ready) begin
        end else if (send_gap > 0) begin
            req_if.valid <= 0;
            send_gap <= send_gap - 1;
        end else if (pending_q.size() > 0 && !hold_send) begin
            t_req rq;
            rq = pending_q.pop_front();
            expected_q.push_back(predict_stack(rq));
            req_if.valid <= 1;
            req_if.opcode <= rq.opcode;
            req_if.layer_id <= rq.layer_id;
            req_if.new_height <= rq.new_height;
            send_gap <= pick_gap();
        end else begin
            req_if.valid <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 0;
            recv_gap <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_rsp got;
                t_rsp exp_r;
                got = {rsp_if.result_layer, rsp_if.ok, rsp_if.applied_height,
                       rsp_if.visible_count, rsp_if.refresh_needed};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item %p", $time, got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    end
                end
            end
            if (recv_gap > 0) begin
                rsp_if.ready <= 0;
                recv_gap <= recv_gap - 1;
            end else begin
                rsp_if.ready <= 1;
                recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        int r;
        errors = 0;
        stim_done = 0;
        hold_send = 0;
        top_m = -1;
        for (int i = 0; i < NL; i++) begin
            used_m[i] = 0;
            hgt_m[i] = -1;
            seq_m[i] = 0;
        end
        req_if.valid = 0;
        req_if.opcode = lzm_pkg::OP_ALLOC;
        req_if.layer_id = 0;
        req_if.new_height = 0;
        rsp_if.ready = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: refusals, alloc, moves, clamps, frees, unknown opcode
        push_req(lzm_pkg::OP_SET, 5, 0);
        push_req(lzm_pkg::OP_FREE, 255, 0);
        push_req(OP_BAD, 8'hA5, 9'sd3);
        for (int i = 0; i < 4; i++) push_req(lzm_pkg::OP_ALLOC, $urandom, 0);
        push_req(lzm_pkg::OP_SET, 0, 255);
        push_req(lzm_pkg::OP_SET, 1, 0);
        push_req(lzm_pkg::OP_SET, 2, -256);
        push_req(lzm_pkg::OP_SET, 2, 1);
        push_req(lzm_pkg::OP_SET, 3, 200);
        push_req(lzm_pkg::OP_SET, 3, 2);
        push_req(lzm_pkg::OP_SET, 1, 255);
        push_req(lzm_pkg::OP_SET, 1, 2);
        push_req(lzm_pkg::OP_SET, 0, -1);
        push_req(lzm_pkg::OP_SET, 0, -1);
        push_req(lzm_pkg::OP_FREE, 2, 0);
        push_req(lzm_pkg::OP_FREE, 0, 0);
        push_req(lzm_pkg::OP_FREE, 0, 0);
        push_req(lzm_pkg::OP_SET, 3, 9'h155);
        push_req(OP_BAD, 8'h5A, -9'sd2);
        while (pending_q.size() > 0) @(posedge i_clk);

        // fill the pool completely, overflow alloc, show every layer, then free
        wait (expected_q.size() == 0);
        hold_send = 1;
        for (int i = 0; i < NL + 1; i++) push_req(lzm_pkg::OP_ALLOC, 0, 0);
        for (int i = 0; i < NL; i++) push_req(lzm_pkg::OP_SET, i, $urandom_range(0, 255));
        push_req(lzm_pkg::OP_SET, 7, 255);
        push_req(lzm_pkg::OP_SET, 9, 0);
        for (int i = 0; i < 40; i++) push_req(lzm_pkg::OP_FREE, $urandom_range(0, 255), 0);
        hold_send = 0;
        while (pending_q.size() > 0) @(posedge i_clk);

        // random: mostly valid ops on a moderate pool
        for (int n = 0; n < 370; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20) push_req(lzm_pkg::OP_ALLOC, $urandom, $urandom);
            else if (r < 75) push_req(lzm_pkg::OP_SET, $urandom_range(0, 40),
                                      $urandom_range(0, 9) == 0 ? $urandom
                                                                : $urandom_range(0, 45) - 1);
            else if (r < 92) push_req(lzm_pkg::OP_FREE, $urandom_range(0, 40), $urandom);
            else if (r < 96) push_req(2'($urandom_range(0, 3)), $urandom, $urandom);
            else push_req(OP_BAD, $urandom, $urandom);
            if (n == 200) begin
                while (pending_q.size() > 0) @(posedge i_clk);
                hold_send = 1;
                wait (expected_q.size() == 0);
                hold_send = 0;
            end
        end
        while (pending_q.size() > 0) @(posedge i_clk);
        wait (expected_q.size() == 0);
        repeat (600) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
